FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

FILE: src/tlfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlfp_pkg
// Types and fixed constants of the tag list frame parser.
// ----------------------------------------------------------------------------
package tlfp_pkg;

  localparam int unsigned COUNT_AT     = 4;
  localparam int unsigned RECORDS_AT   = 5;
  localparam int unsigned CRC_BYTES    = 2;
  localparam int unsigned HEADER_BYTES = 1;

  localparam int unsigned REC_POS_W = 4;
  localparam int unsigned REC_IDX_W = 5;
  localparam int unsigned EXP_W     = 10;

  localparam logic KIND_TAG     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_LONG      = 3'd2;
  localparam logic [2:0] ST_LEN_BYTE  = 3'd3;
  localparam logic [2:0] ST_TOO_MANY  = 3'd4;
  localparam logic [2:0] ST_COUNT_LEN = 3'd5;
  localparam logic [2:0] ST_BAD_REC   = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] tag_slot;
    logic [3:0] byte_slot;
    logic [7:0] tag_byte;
    logic [2:0] status;
    logic [4:0] num_tags;
  } out_word_t;

endpackage

FILE: src/tag_list_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_list_frame_parser_unit
// Checks a reader response frame one byte per word, emits tag bytes and a
// verdict on the last byte.
// ----------------------------------------------------------------------------
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a held result stalls in_ready; the result register frees as it is taken.
// Reset (rst, synchronous): clears frame counters, flags and out_valid.
`include "assert_macros.svh"

module tag_list_frame_parser_unit #(
  parameter int unsigned TAG_RAW_LEN    = 12,
  parameter int unsigned TAG_UPLOAD_LEN = 12,
  parameter int unsigned MAX_TAGS       = 16,
  parameter int unsigned MAX_FRAME_LEN  = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlfp_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tlfp_pkg::out_word_t  out_word
);
  import tlfp_pkg::*;

  localparam int unsigned POS_W     = $clog2(MAX_FRAME_LEN + 2);
  localparam int unsigned REC_BYTES = HEADER_BYTES + TAG_RAW_LEN;

  logic [POS_W-1:0]     frame_position, frame_position_next;
  logic [7:0]           declared_length, declared_length_next;
  logic [7:0]           count_seen, count_seen_next;
  logic [REC_POS_W-1:0] record_position, record_position_next;
  logic [REC_IDX_W-1:0] record_index, record_index_next;
  logic                 record_error, record_error_next;

  logic      fire;
  logic      walk;
  logic      emit;
  logic      produce;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       dl_now;
  logic [7:0]       cnt_now;
  logic             err_now;
  logic [EXP_W-1:0] expected;
  logic [2:0]       verdict;
  out_word_t        result;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    dl_now  = (frame_position == '0) ? in_word.data_byte : declared_length;
    cnt_now = (frame_position == POS_W'(COUNT_AT)) ? in_word.data_byte : count_seen;
    walk = (frame_position >= POS_W'(RECORDS_AT))
        && ({3'b000, record_index} < cnt_now)
        && (record_index < REC_IDX_W'(MAX_TAGS));
    emit = 1'b0;
    err_now = record_error;
    record_position_next = record_position;
    record_index_next    = record_index;
    if (walk) begin
      if (record_position == '0) begin
        if (in_word.data_byte != 8'(TAG_RAW_LEN)) err_now = 1'b1;
      end else if ((record_position - 1'b1) < REC_POS_W'(TAG_UPLOAD_LEN)) begin
        emit = 1'b1;
      end
      if (record_position >= REC_POS_W'(TAG_RAW_LEN)) begin
        record_position_next = '0;
        record_index_next    = record_index + 1'b1;
      end else begin
        record_position_next = record_position + 1'b1;
      end
    end
    pos_inc = (frame_position <= POS_W'(MAX_FRAME_LEN)) ? frame_position + 1'b1
                                                        : frame_position;
  end

  // expected length only matters once the count is within MAX_TAGS
  assign expected = EXP_W'(RECORDS_AT + CRC_BYTES)
                  + EXP_W'(cnt_now[4:0]) * EXP_W'(REC_BYTES);

  always_comb begin
    if (pos_inc < POS_W'(RECORDS_AT + CRC_BYTES)) verdict = ST_SHORT;
    else if (EXP_W'(pos_inc) > EXP_W'(MAX_FRAME_LEN)) verdict = ST_LONG;
    else if (EXP_W'(dl_now) + 1'b1 != EXP_W'(pos_inc)) verdict = ST_LEN_BYTE;
    else if (cnt_now > 8'(MAX_TAGS)) verdict = ST_TOO_MANY;
    else if (EXP_W'(pos_inc) != expected) verdict = ST_COUNT_LEN;
    else if (err_now) verdict = ST_BAD_REC;
    else verdict = ST_OK;
  end

  always_comb begin
    result = '0;
    if (in_word.frame_end) begin
      result.result_kind = KIND_VERDICT;
      result.status      = verdict;
      result.num_tags    = (cnt_now > 8'd31) ? 5'd31 : cnt_now[4:0];
    end else begin
      result.result_kind = KIND_TAG;
      result.tag_slot    = record_index[3:0];
      result.byte_slot   = record_position - 1'b1;
      result.tag_byte    = in_word.data_byte;
    end
    produce = in_word.frame_end || emit;
  end

  always_comb begin
    if (in_word.frame_end) begin
      frame_position_next  = '0;
      declared_length_next = '0;
      count_seen_next      = '0;
      record_error_next    = 1'b0;
    end else begin
      frame_position_next  = pos_inc;
      declared_length_next = dl_now;
      count_seen_next      = cnt_now;
      record_error_next    = err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position  <= '0;
      declared_length <= '0;
      count_seen      <= '0;
      record_position <= '0;
      record_index    <= '0;
      record_error    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (fire) begin
        frame_position  <= frame_position_next;
        declared_length <= declared_length_next;
        count_seen      <= count_seen_next;
        record_error    <= record_error_next;
        record_position <= in_word.frame_end ? '0 : record_position_next;
        record_index    <= in_word.frame_end ? '0 : record_index_next;
        out_valid       <= produce;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_word <= result;
    end
  end

  `ASSERT_NEVER(a_rec_pos_range, clk, rst, record_position > REC_POS_W'(TAG_RAW_LEN))
  `ASSERT_NEVER(a_rec_idx_range, clk, rst, record_index > REC_IDX_W'(MAX_TAGS))
  `ASSERT_NEVER(a_pos_range, clk, rst, frame_position > POS_W'(MAX_FRAME_LEN + 1))
  `ASSERT_NEXT(a_frame_clear, clk, rst, fire && in_word.frame_end,
    frame_position == '0 && record_index == '0 && !record_error)
  `ASSERT_IMPLIES(a_verdict_clean, clk, rst,
    out_valid && out_word.result_kind == KIND_VERDICT,
    out_word.tag_slot == '0 && out_word.byte_slot == '0 && out_word.tag_byte == '0)

endmodule

FILE: test/tag_list_frame_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_list_frame_parser_unit_tb
// Self-checking bench for the tag list frame parser: a short table of
// hand-checked frames, then random well-formed, damaged and noise frames,
// each byte predicted in the bench and compared with the unit's output
// under random stalls on both handshakes.
// ----------------------------------------------------------------------------
module tag_list_frame_parser_unit_tb;
  import tlfp_pkg::*;

  localparam int unsigned TAG_RAW_LEN    = 12;
  localparam int unsigned TAG_UPLOAD_LEN = 12;
  localparam int unsigned MAX_TAGS       = 16;
  localparam int unsigned MAX_FRAME_LEN  = 256;
  localparam int unsigned REC_LEN        = HEADER_BYTES + TAG_RAW_LEN;

  localparam int unsigned BYTE_TARGET = 1600;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 8;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t r;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // bench copy of the parser state
  int unsigned frame_pos, decl_len, count_byte, rec_pos, rec_idx;
  bit          rec_bad;

  out_word_t   pending_results[$];
  in_word_t    frame_q[$];
  dir_row_t    dir_rows[$];

  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_bytes = 0, n_frames = 0, n_tag_bytes = 0, n_verdicts = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  tag_list_frame_parser_unit #(
    .TAG_RAW_LEN   (TAG_RAW_LEN),
    .TAG_UPLOAD_LEN(TAG_UPLOAD_LEN),
    .MAX_TAGS      (MAX_TAGS),
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic clear_frame_state();
    frame_pos  = 0;
    decl_len   = 0;
    count_byte = 0;
    rec_pos    = 0;
    rec_idx    = 0;
    rec_bad    = 1'b0;
  endtask

  task automatic parse_byte(input in_word_t w, output bit has, output out_word_t r);
    int unsigned b, flen;
    logic [2:0]  st;
    bit          emit;
    b    = 32'(w.data_byte);
    emit = 1'b0;
    has  = 1'b0;
    r    = '0;
    if (frame_pos == 0) decl_len = b;
    if (frame_pos == COUNT_AT) count_byte = b;
    if (frame_pos >= RECORDS_AT && rec_idx < count_byte && rec_idx < MAX_TAGS) begin
      if (rec_pos == 0) begin
        if (b != TAG_RAW_LEN) rec_bad = 1'b1;
      end else if (rec_pos - 1 < TAG_UPLOAD_LEN) begin
        emit       = 1'b1;
        r.tag_slot  = 4'(rec_idx);
        r.byte_slot = 4'(rec_pos - 1);
        r.tag_byte  = 8'(b);
      end
      if (rec_pos >= TAG_RAW_LEN) begin
        rec_pos = 0;
        rec_idx++;
      end else begin
        rec_pos++;
      end
    end
    if (frame_pos <= MAX_FRAME_LEN) frame_pos++;
    if (w.frame_end) begin
      flen = frame_pos;
      if (flen < RECORDS_AT + CRC_BYTES) st = ST_SHORT;
      else if (flen > MAX_FRAME_LEN) st = ST_LONG;
      else if (decl_len + 1 != flen) st = ST_LEN_BYTE;
      else if (count_byte > MAX_TAGS) st = ST_TOO_MANY;
      else if (flen != RECORDS_AT + count_byte * REC_LEN + CRC_BYTES) st = ST_COUNT_LEN;
      else if (rec_bad) st = ST_BAD_REC;
      else st = ST_OK;
      r             = '0;
      r.result_kind = KIND_VERDICT;
      r.status      = st;
      r.num_tags    = (count_byte > 31) ? 5'd31 : 5'(count_byte);
      has           = 1'b1;
      clear_frame_state();
    end else if (emit) begin
      r.result_kind = KIND_TAG;
      has           = 1'b1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic out_word_t verdict_of(logic [2:0] st, logic [4:0] cnt);
    out_word_t r;
    r             = '0;
    r.result_kind = KIND_VERDICT;
    r.status      = st;
    r.num_tags    = cnt;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input out_word_t r);
    dir_row_t row;
    row.w     = {b, last};
    row.typed = typed;
    row.r     = r;
    dir_rows.push_back(row);
  endtask

  // entered and left at a falling edge
  task automatic send_word(input in_word_t w, input bit use_typed, input out_word_t typed_r);
    int unsigned gap;
    bit          has;
    out_word_t   r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    parse_byte(w, has, r);
    if (has) pending_results.push_back(use_typed ? typed_r : r);
    n_bytes++;
    if (w.frame_end) n_frames++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic build_body(input int unsigned cnt);
    int unsigned len;
    len = RECORDS_AT + cnt * REC_LEN + CRC_BYTES;
    frame_q.push_back({8'(len - 1), 1'b0});
    repeat (COUNT_AT - 1) frame_q.push_back({8'($urandom), 1'b0});
    frame_q.push_back({8'(cnt), 1'b0});
    repeat (cnt) begin
      frame_q.push_back({8'(TAG_RAW_LEN), 1'b0});
      repeat (TAG_RAW_LEN) frame_q.push_back({8'($urandom), 1'b0});
    end
    repeat (CRC_BYTES) frame_q.push_back({8'($urandom), 1'b0});
  endtask

  task automatic build_frame();
    int unsigned kind, sel, cnt, off, n;
    logic [7:0]  bad;
    frame_q.delete();
    kind = $urandom_range(0, 9);
    sel  = $urandom_range(0, 15);
    if (sel == 0) cnt = MAX_TAGS;
    else if (sel < 4) cnt = $urandom_range(4, MAX_TAGS - 1);
    else cnt = $urandom_range(0, 3);
    if (kind <= 5) begin
      build_body(cnt);
    end else if (kind == 6) begin
      if (cnt == 0) cnt = 1;
      build_body(cnt);
      bad = 8'($urandom);
      if (bad == 8'(TAG_RAW_LEN)) bad = 8'h00;
      frame_q[RECORDS_AT + $urandom_range(0, cnt - 1) * REC_LEN].data_byte = bad;
    end else if (kind == 7) begin
      sel = $urandom_range(0, 2);
      if (sel == 2) begin
        build_body($urandom_range(MAX_TAGS + 1, MAX_TAGS + 3));
      end else begin
        build_body(cnt);
        if (sel == 0) begin
          off = $urandom_range(1, 5);
          if ($urandom_range(0, 1) == 1 && frame_q.size() >= off + 7)
            repeat (off) void'(frame_q.pop_back());
          else
            repeat (off) frame_q.push_back({8'($urandom), 1'b0});
          frame_q[0].data_byte = 8'(frame_q.size() - 1);
        end else begin
          frame_q[0].data_byte = frame_q[0].data_byte ^ 8'($urandom_range(1, 255));
        end
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back({8'($urandom), 1'b0});
    end else begin
      if ($urandom_range(0, 3) == 0) n = $urandom_range(MAX_FRAME_LEN + 1, MAX_FRAME_LEN + 44);
      else n = $urandom_range(7, 40);
      repeat (n) frame_q.push_back({8'($urandom), 1'b0});
    end
    frame_q[frame_q.size() - 1].frame_end = 1'b1;
  endtask

  // stimulus and end of run
  initial begin
    int unsigned fnum;
    clear_frame_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one-byte frame: header bytes missing, short
    add_row(8'hFF, 1'b1, 1'b1, verdict_of(ST_SHORT, 5'd0));
    // smallest valid frame, no tags
    add_row(8'h06, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b1, 1'b1, verdict_of(ST_OK, 5'd0));
    // length byte wrong, count saturates, tag byte on the last byte gives way
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, verdict_of(ST_LEN_BYTE, 5'd31));
    // too many tags beats the bad record length
    add_row(8'h06, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h03, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b1, 1'b1, verdict_of(ST_TOO_MANY, 5'd17));

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
    drain_results();

    fnum = 0;
    while (n_bytes < BYTE_TARGET) begin
      build_frame();
      calm = ($urandom_range(0, 5) == 0);
      if (fnum % 30 == 3) hold_req = 1'b1;
      foreach (frame_q[i]) send_word(frame_q[i], 1'b0, '0);
      if (fnum % 25 == 12) drain_results();
      fnum++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d bytes in %0d frames sent; %0d tag bytes and %0d verdicts compared",
             n_bytes, n_frames, n_tag_bytes, n_verdicts);
    $display("stalls on both sides, %0d long receiver holds, %0d mismatches",
             (fnum + 26) / 30, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side ready
  initial begin
    int unsigned n, g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (n) @(negedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch at %0t: %s got %0d, want %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected word, kind", 32'(out_word.result_kind), 0);
        end else begin
          want = pending_results.pop_front();
          if (want.result_kind == KIND_VERDICT) n_verdicts++;
          else n_tag_bytes++;
          if (out_word.result_kind !== want.result_kind)
            flag_mismatch("result_kind", 32'(out_word.result_kind),
                          32'(want.result_kind));
          if (out_word.tag_slot !== want.tag_slot)
            flag_mismatch("tag_slot", 32'(out_word.tag_slot), 32'(want.tag_slot));
          if (out_word.byte_slot !== want.byte_slot)
            flag_mismatch("byte_slot", 32'(out_word.byte_slot), 32'(want.byte_slot));
          if (out_word.tag_byte !== want.tag_byte)
            flag_mismatch("tag_byte", 32'(out_word.tag_byte), 32'(want.tag_byte));
          if (out_word.status !== want.status)
            flag_mismatch("status", 32'(out_word.status), 32'(want.status));
          if (out_word.num_tags !== want.num_tags)
            flag_mismatch("num_tags", 32'(out_word.num_tags), 32'(want.num_tags));
        end
      end
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/tlfp_pkg.sv
src/tag_list_frame_parser_unit.sv
test/tag_list_frame_parser_unit_tb.sv
